// ===== src/chained_hash_size_registry_macros.svh =====
// Assertion macros for the chained hash size registry.
// Used by the top level; expects clk and arst_n in scope.
`ifndef CHAINED_HASH_SIZE_REGISTRY_MACROS_SVH
`define CHAINED_HASH_SIZE_REGISTRY_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define CHR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CHR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/chr_pkg.sv =====
// Shared constants, codes and the entry record type of the hash size registry.
// No dependencies.
`timescale 1ns / 1ps

package chr_pkg;

	localparam int DEF_MAX_ENTRIES  = 8192;
	localparam int DEF_BUCKET_COUNT = 16384;

	localparam logic [31:0] HASH_MULT = 32'h9e3779b1;
	localparam int HASH_SHIFT_IN  = 4;
	localparam int HASH_SHIFT_MIX = 17;
	localparam int HASH_SHIFT_OUT = 16;

	localparam int OP_W      = 3;
	localparam int STATUS_W  = 3;
	localparam int REMOVED_W = 14;

	localparam logic [OP_W-1:0] OP_REGISTER    = 3'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP      = 3'd1;
	localparam logic [OP_W-1:0] OP_REMOVE_KEY  = 3'd2;
	localparam logic [OP_W-1:0] OP_REMOVE_HEAP = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR       = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_UPDATED   = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_DROPPED   = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_IGNORED   = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_FOUND     = 3'd4;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd5;
	localparam logic [STATUS_W-1:0] STAT_REMOVED   = 3'd6;
	localparam logic [STATUS_W-1:0] STAT_CLEARED   = 3'd7;

	typedef struct packed {
		logic [31:0] tag;
		logic [31:0] heap;
		logic [31:0] size;
		logic [63:0] addr_key;
	} rec_t;

endpackage

// ===== src/chr_hash.sv =====
// Bucket hash of a 64-bit key: shift, xor, multiply, xor, then mask.
// Depends on chr_pkg. One register after the multiplier.
`timescale 1ns / 1ps

module chr_hash #(
	parameter int BUCKET_COUNT = chr_pkg::DEF_BUCKET_COUNT
) (
	input  logic                            clk,
	input  logic [63:0]                     key,
	output logic [$clog2(BUCKET_COUNT)-1:0] bucket
);

	localparam int BK_W = $clog2(BUCKET_COUNT);
	localparam int HW   = BK_W + chr_pkg::HASH_SHIFT_OUT;

	logic [63:0]   mixed;
	logic [HW-1:0] prod_full;
	logic [HW-1:0] prod_q;

	assign mixed = (key >> chr_pkg::HASH_SHIFT_IN)
		^ (key >> (chr_pkg::HASH_SHIFT_IN + chr_pkg::HASH_SHIFT_MIX));
	assign prod_full = mixed[HW-1:0] * HW'(chr_pkg::HASH_MULT);

	always_ff @(posedge clk) begin
		prod_q <= prod_full;
	end

	assign bucket = prod_q[BK_W-1:0] ^ prod_q[HW-1:chr_pkg::HASH_SHIFT_OUT];

endmodule

// ===== src/chr_store.sv =====
// Link memory (bucket heads followed by entry next links) and entry record memory.
// Depends on chr_pkg. Both memories read synchronously, with registered read data.
`timescale 1ns / 1ps

module chr_store #(
	parameter int MAX_ENTRIES  = chr_pkg::DEF_MAX_ENTRIES,
	parameter int BUCKET_COUNT = chr_pkg::DEF_BUCKET_COUNT
) (
	input  logic                                         clk,
	input  logic                                         link_we,
	input  logic [$clog2(BUCKET_COUNT+MAX_ENTRIES)-1:0]  link_waddr,
	input  logic [$clog2(MAX_ENTRIES+1)-1:0]             link_wdata,
	input  logic [$clog2(BUCKET_COUNT+MAX_ENTRIES)-1:0]  link_raddr,
	output logic [$clog2(MAX_ENTRIES+1)-1:0]             link_rdata,
	input  logic                                         data_we,
	input  logic [$clog2(MAX_ENTRIES)-1:0]               data_waddr,
	input  chr_pkg::rec_t                                data_wdata,
	input  logic [$clog2(MAX_ENTRIES)-1:0]               data_raddr,
	output chr_pkg::rec_t                                data_rdata
);

	localparam int IDX_W = $clog2(MAX_ENTRIES + 1);

	logic [IDX_W-1:0] link_mem [BUCKET_COUNT+MAX_ENTRIES];
	chr_pkg::rec_t    data_mem [MAX_ENTRIES];

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end
		link_rdata <= link_mem[link_raddr];
	end

	always_ff @(posedge clk) begin
		if (data_we) begin
			data_mem[data_waddr] <= data_wdata;
		end
		data_rdata <= data_mem[data_raddr];
	end

endmodule

// ===== src/chained_hash_size_registry.sv =====
// Register and lookup (hit or miss) hash the key, read the bucket head and walk the chain.
// Insert then writes the record and link; remove by key unlinks, and when the last entry
// moves, reads it, walks its chain, relinks and moves it. Remove by heap and tag reads and
// checks each entry, plus that removal per match. One transaction is in work at a time.
// After reset, and for a clear, a sweep zeroes all BUCKET_COUNT + MAX_ENTRIES link words;
// no input is accepted during it. Depends on chr_pkg, chr_hash, chr_store and macros.
`timescale 1ns / 1ps
`include "chained_hash_size_registry_macros.svh"

module chained_hash_size_registry #(
	parameter int MAX_ENTRIES  = chr_pkg::DEF_MAX_ENTRIES,
	parameter int BUCKET_COUNT = chr_pkg::DEF_BUCKET_COUNT
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// address_key[63:0], requested_size[95:64], heap_id[127:96],
	// allocation_size[159:128], lifetime_tag[191:160]
	input  logic [191:0] s_tdata,
	// operation[2:0], block_info_valid[3]
	input  logic [3:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// found_size[31:0], removed_count[45:32], zero[47:46]
	output logic [47:0]  m_tdata,
	// status[2:0]
	output logic [2:0]   m_tuser
);

	localparam int IX_W  = $clog2(MAX_ENTRIES);
	localparam int IDX_W = $clog2(MAX_ENTRIES + 1);
	localparam int LA_W  = $clog2(BUCKET_COUNT + MAX_ENTRIES);
	localparam int BK_W  = $clog2(BUCKET_COUNT);

	typedef enum logic [16:0] {
		ST_IDLE     = 17'h00001,
		ST_HASH     = 17'h00002,
		ST_HEAD     = 17'h00004,
		ST_HCHK     = 17'h00008,
		ST_STEP     = 17'h00010,
		ST_WEND     = 17'h00020,
		ST_INS_WR   = 17'h00040,
		ST_INS_LINK = 17'h00080,
		ST_UNLINK   = 17'h00100,
		ST_LAST_RD  = 17'h00200,
		ST_LAST_CHK = 17'h00400,
		ST_RELINK   = 17'h00800,
		ST_MOVE     = 17'h01000,
		ST_SCAN_RD  = 17'h02000,
		ST_SCAN_CHK = 17'h04000,
		ST_SWEEP    = 17'h08000,
		ST_DONE     = 17'h10000
	} state_t;

	typedef enum logic [1:0] {
		WF_MAIN = 2'd0,
		WF_LAST = 2'd1,
		WF_SCAN = 2'd2
	} walk_for_t;

	state_t                         state_q;
	walk_for_t                      walk_for_q;
	logic                           boot_q;
	logic [IDX_W-1:0]               count_q;
	logic [IDX_W-1:0]               removed_q;
	logic [IDX_W-1:0]               scan_q;
	logic [LA_W-1:0]                sweep_q;
	logic [chr_pkg::OP_W-1:0]       op_q;
	logic [chr_pkg::STATUS_W-1:0]   status_q;
	logic [31:0]                    found_q;
	logic [31:0]                    size_q;
	logic [31:0]                    heap_q;
	logic [31:0]                    tag_q;
	logic [63:0]                    key_q;
	logic [63:0]                    walk_key_q;
	logic                           wfound_q;
	logic [LA_W-1:0]                loc_q;
	logic [IDX_W-1:0]               v_q;
	logic [IDX_W-1:0]               nxt_q;
	logic [31:0]                    hit_size_q;
	logic [IX_W-1:0]                index_q;
	logic [LA_W-1:0]                loc1_q;
	logic [IDX_W-1:0]               next_i_q;
	chr_pkg::rec_t                  lrec_q;
	logic [IDX_W-1:0]               lnext_q;
	logic                           m_tvalid_q;
	logic [47:0]                    m_tdata_q;
	logic [2:0]                     m_tuser_q;

	logic [BK_W-1:0]                bucket;
	logic                           link_we;
	logic [LA_W-1:0]                link_waddr;
	logic [IDX_W-1:0]               link_wdata;
	logic [LA_W-1:0]                link_raddr;
	logic [IDX_W-1:0]               link_rdata;
	logic                           data_we;
	logic [IX_W-1:0]                data_waddr;
	chr_pkg::rec_t                  data_wdata;
	logic [IX_W-1:0]                data_raddr;
	chr_pkg::rec_t                  data_rdata;

	logic [chr_pkg::OP_W-1:0]       in_op;
	logic                           in_info;
	logic [63:0]                    in_key;
	logic [31:0]                    in_size;
	logic [31:0]                    in_heap;
	logic [31:0]                    in_alloc;
	logic [31:0]                    in_tag;
	logic                           key_hit;
	logic                           scan_hit;
	logic [IX_W-1:0]                after_unlink_dummy;
	state_t                         after_remove;

	assign in_op    = s_tuser[2:0];
	assign in_info  = s_tuser[3];
	assign in_key   = s_tdata[63:0];
	assign in_size  = s_tdata[95:64];
	assign in_heap  = s_tdata[127:96];
	assign in_alloc = s_tdata[159:128];
	assign in_tag   = s_tdata[191:160];

	assign key_hit  = (data_rdata.addr_key == walk_key_q);
	assign scan_hit = (data_rdata.heap == heap_q) && (data_rdata.tag == tag_q);
	assign after_remove = (op_q == chr_pkg::OP_REMOVE_HEAP) ? ST_SCAN_RD : ST_DONE;
	assign after_unlink_dummy = IX_W'(v_q - IDX_W'(1));

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	chr_hash #(
		.BUCKET_COUNT(BUCKET_COUNT)
	) u_hash (
		.clk   (clk),
		.key   (walk_key_q),
		.bucket(bucket)
	);

	chr_store #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.BUCKET_COUNT(BUCKET_COUNT)
	) u_store (
		.clk       (clk),
		.link_we   (link_we),
		.link_waddr(link_waddr),
		.link_wdata(link_wdata),
		.link_raddr(link_raddr),
		.link_rdata(link_rdata),
		.data_we   (data_we),
		.data_waddr(data_waddr),
		.data_wdata(data_wdata),
		.data_raddr(data_raddr),
		.data_rdata(data_rdata)
	);

	always_comb begin
		link_raddr = '0;
		data_raddr = '0;
		case (state_q)
			ST_HEAD: begin
				link_raddr = LA_W'(bucket);
			end
			ST_HCHK: begin
				link_raddr = LA_W'(BUCKET_COUNT - 1) + LA_W'(link_rdata);
				data_raddr = IX_W'(link_rdata - IDX_W'(1));
			end
			ST_STEP: begin
				link_raddr = LA_W'(BUCKET_COUNT - 1) + LA_W'(link_rdata);
				data_raddr = IX_W'(link_rdata - IDX_W'(1));
			end
			ST_LAST_RD: begin
				link_raddr = LA_W'(BUCKET_COUNT) + LA_W'(count_q);
				data_raddr = count_q[IX_W-1:0];
			end
			ST_SCAN_RD: begin
				link_raddr = LA_W'(BUCKET_COUNT) + LA_W'(scan_q);
				data_raddr = scan_q[IX_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		link_we    = 1'b0;
		link_waddr = '0;
		link_wdata = '0;
		data_we    = 1'b0;
		data_waddr = '0;
		data_wdata = '{tag: tag_q, heap: heap_q, size: size_q, addr_key: key_q};
		case (state_q)
			ST_WEND: begin
				if (walk_for_q == WF_MAIN && op_q == chr_pkg::OP_REGISTER && wfound_q) begin
					data_we    = 1'b1;
					data_waddr = after_unlink_dummy;
				end
			end
			ST_INS_WR: begin
				data_we    = 1'b1;
				data_waddr = count_q[IX_W-1:0];
				link_we    = 1'b1;
				link_waddr = LA_W'(BUCKET_COUNT) + LA_W'(count_q);
			end
			ST_INS_LINK: begin
				link_we    = 1'b1;
				link_waddr = loc_q;
				link_wdata = count_q + IDX_W'(1);
			end
			ST_UNLINK: begin
				link_we    = 1'b1;
				link_waddr = loc1_q;
				link_wdata = next_i_q;
			end
			ST_RELINK: begin
				link_we    = 1'b1;
				link_waddr = loc_q;
				link_wdata = IDX_W'(index_q) + IDX_W'(1);
			end
			ST_MOVE: begin
				data_we    = 1'b1;
				data_waddr = index_q;
				data_wdata = lrec_q;
				link_we    = 1'b1;
				link_waddr = LA_W'(BUCKET_COUNT) + LA_W'(index_q);
				link_wdata = lnext_q;
			end
			ST_SWEEP: begin
				link_we    = 1'b1;
				link_waddr = sweep_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_SWEEP;
			boot_q     <= 1'b1;
			count_q    <= '0;
			sweep_q    <= '0;
			m_tvalid_q <= 1'b0;
			walk_for_q <= WF_MAIN;
		end else begin
			if (m_tvalid_q && m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q       <= in_op;
						key_q      <= in_key;
						walk_key_q <= in_key;
						walk_for_q <= WF_MAIN;
						found_q    <= '0;
						removed_q  <= (in_op == chr_pkg::OP_CLEAR) ? count_q : '0;
						size_q     <= (in_op == chr_pkg::OP_REGISTER && in_info
							&& in_size > in_alloc) ? in_alloc : in_size;
						heap_q     <= (in_op == chr_pkg::OP_REGISTER && !in_info)
							? 32'hFFFF_FFFF : in_heap;
						tag_q      <= (in_op == chr_pkg::OP_REGISTER && !in_info)
							? '0 : in_tag;
						case (in_op)
							chr_pkg::OP_REGISTER: begin
								if (in_key == '0 || in_size == '0) begin
									status_q <= chr_pkg::STAT_IGNORED;
									state_q  <= ST_DONE;
								end else begin
									state_q <= ST_HASH;
								end
							end
							chr_pkg::OP_LOOKUP, chr_pkg::OP_REMOVE_KEY: begin
								if (in_key == '0) begin
									status_q <= chr_pkg::STAT_NOT_FOUND;
									state_q  <= ST_DONE;
								end else begin
									state_q <= ST_HASH;
								end
							end
							chr_pkg::OP_REMOVE_HEAP: begin
								scan_q  <= '0;
								state_q <= ST_SCAN_RD;
							end
							chr_pkg::OP_CLEAR: begin
								status_q  <= chr_pkg::STAT_CLEARED;
								count_q   <= '0;
								sweep_q   <= '0;
								state_q   <= ST_SWEEP;
							end
							default: begin
								status_q <= chr_pkg::STAT_IGNORED;
								state_q  <= ST_DONE;
							end
						endcase
					end
				end
				ST_HASH: begin
					state_q <= ST_HEAD;
				end
				ST_HEAD: begin
					loc_q   <= LA_W'(bucket);
					state_q <= ST_HCHK;
				end
				ST_HCHK: begin
					if (link_rdata == '0) begin
						wfound_q <= 1'b0;
						state_q  <= ST_WEND;
					end else begin
						v_q     <= link_rdata;
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (key_hit) begin
						hit_size_q <= data_rdata.size;
						nxt_q      <= link_rdata;
						wfound_q   <= 1'b1;
						state_q    <= ST_WEND;
					end else begin
						loc_q <= LA_W'(BUCKET_COUNT - 1) + LA_W'(v_q);
						if (link_rdata == '0) begin
							wfound_q <= 1'b0;
							state_q  <= ST_WEND;
						end else begin
							v_q <= link_rdata;
						end
					end
				end
				ST_WEND: begin
					case (walk_for_q)
						WF_MAIN: begin
							case (op_q)
								chr_pkg::OP_REGISTER: begin
									if (wfound_q) begin
										status_q <= chr_pkg::STAT_UPDATED;
										state_q  <= ST_DONE;
									end else if (count_q < IDX_W'(MAX_ENTRIES)) begin
										state_q <= ST_INS_WR;
									end else begin
										status_q <= chr_pkg::STAT_DROPPED;
										state_q  <= ST_DONE;
									end
								end
								chr_pkg::OP_LOOKUP: begin
									if (wfound_q) begin
										found_q  <= hit_size_q;
										status_q <= chr_pkg::STAT_FOUND;
									end else begin
										status_q <= chr_pkg::STAT_NOT_FOUND;
									end
									state_q <= ST_DONE;
								end
								default: begin
									if (wfound_q) begin
										index_q   <= after_unlink_dummy;
										loc1_q    <= loc_q;
										next_i_q  <= nxt_q;
										removed_q <= IDX_W'(1);
										status_q  <= chr_pkg::STAT_REMOVED;
										state_q   <= ST_UNLINK;
									end else begin
										status_q <= chr_pkg::STAT_NOT_FOUND;
										state_q  <= ST_DONE;
									end
								end
							endcase
						end
						WF_SCAN: begin
							index_q   <= after_unlink_dummy;
							loc1_q    <= loc_q;
							next_i_q  <= nxt_q;
							removed_q <= removed_q + IDX_W'(1);
							state_q   <= ST_UNLINK;
						end
						default: begin
							state_q <= ST_RELINK;
						end
					endcase
				end
				ST_INS_WR: begin
					state_q <= ST_INS_LINK;
				end
				ST_INS_LINK: begin
					count_q  <= count_q + IDX_W'(1);
					status_q <= chr_pkg::STAT_INSERTED;
					state_q  <= ST_DONE;
				end
				ST_UNLINK: begin
					count_q <= count_q - IDX_W'(1);
					if (IDX_W'(index_q) == count_q - IDX_W'(1)) begin
						state_q <= after_remove;
					end else begin
						state_q <= ST_LAST_RD;
					end
				end
				ST_LAST_RD: begin
					state_q <= ST_LAST_CHK;
				end
				ST_LAST_CHK: begin
					lrec_q     <= data_rdata;
					lnext_q    <= link_rdata;
					walk_key_q <= data_rdata.addr_key;
					walk_for_q <= WF_LAST;
					state_q    <= ST_HASH;
				end
				ST_RELINK: begin
					state_q <= ST_MOVE;
				end
				ST_MOVE: begin
					state_q <= after_remove;
				end
				ST_SCAN_RD: begin
					if (scan_q < count_q) begin
						state_q <= ST_SCAN_CHK;
					end else begin
						status_q <= chr_pkg::STAT_REMOVED;
						state_q  <= ST_DONE;
					end
				end
				ST_SCAN_CHK: begin
					if (scan_hit) begin
						walk_key_q <= data_rdata.addr_key;
						walk_for_q <= WF_SCAN;
						state_q    <= ST_HASH;
					end else begin
						scan_q  <= scan_q + IDX_W'(1);
						state_q <= ST_SCAN_RD;
					end
				end
				ST_SWEEP: begin
					sweep_q <= sweep_q + LA_W'(1);
					if (sweep_q == LA_W'(BUCKET_COUNT + MAX_ENTRIES - 1)) begin
						boot_q  <= 1'b0;
						state_q <= boot_q ? ST_IDLE : ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= status_q;
						m_tdata_q  <= {2'b00, chr_pkg::REMOVED_W'(removed_q), found_q};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`CHR_ASSERT_NOW(a_count_bound, 1'b1, count_q <= IDX_W'(MAX_ENTRIES), "entry count above capacity")
	`CHR_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state_q != ST_IDLE, "accepted transaction not started")
	`CHR_ASSERT_NOW(a_sweep_empty, state_q == ST_SWEEP, count_q == '0, "link sweep with entries held")
	`CHR_ASSERT_NOW(a_size_only_found, m_tvalid && m_tuser != chr_pkg::STAT_FOUND, m_tdata[31:0] == '0, "size on a miss")
	`CHR_ASSERT_NEXT(a_insert_grows, state_q == ST_INS_LINK, count_q == IDX_W'($past(count_q) + 1'b1), "insert did not add an entry")

endmodule
